/* rtl/mrps_pkg.sv */
// Shared types, constants and key compare functions for the masked run pixel sorter.
package mrps_pkg;

   localparam int MAX_RUN_DEFAULT = 63;
   localparam int SEQ_W = 6;
   localparam int PIXEL_W = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_INSERT,
      ST_EMIT,
      ST_RESORT
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP,
      OP_SORT
   } cell_op_type;

   typedef struct packed {
      logic               valid;
      logic [PIXEL_W-1:0] pixel;
      logic [SEQ_W-1:0]   seq;
      logic               shift;
   } link_type;

   typedef struct packed {
      cell_op_type        op;
      logic               ascending;
      logic               phase;
      logic [PIXEL_W-1:0] new_pixel;
      logic [SEQ_W-1:0]   new_seq;
   } cell_ctrl_type;

   function automatic logic [7:0] green_of(input logic [PIXEL_W-1:0] p);
      return p[15:8];
   endfunction

   // True when green a must come strictly after green b.
   function automatic logic goes_after(input logic [7:0] a, input logic [7:0] b,
                                       input logic asc);
      return asc ? (a > b) : (a < b);
   endfunction

   // True when entry a must precede entry b; empty entries sort to the end.
   function automatic logic precedes(input link_type a, input link_type b, input logic asc);
      logic [7:0] ga;
      logic [7:0] gb;
      ga = green_of(a.pixel);
      gb = green_of(b.pixel);
      if (!a.valid) return 1'b0;
      if (!b.valid) return 1'b1;
      if (ga == gb) return a.seq < b.seq;
      return goes_after(gb, ga, asc);
   endfunction

endpackage

/* rtl/mrps_cell.sv */
// One cell of the sorted run chain: holds a pixel, its arrival tag and a valid bit.
module mrps_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mrps_pkg::cell_ctrl_type ctrl,
   input  mrps_pkg::link_type    prev_link,
   input  mrps_pkg::link_type    next_link,
   input  logic                  first,
   input  logic                  last_cell,
   input  logic                  odd_pos,
   output mrps_pkg::link_type    link
);
   import mrps_pkg::*;

   logic               valid_ff, valid_in;
   logic [PIXEL_W-1:0] pixel_ff, pixel_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic               shift_self;
   link_type           self_link;

   assign shift_self = valid_ff &&
      goes_after(green_of(pixel_ff), green_of(ctrl.new_pixel), ctrl.ascending);

   always_comb begin
      self_link.valid = valid_ff;
      self_link.pixel = pixel_ff;
      self_link.seq   = seq_ff;
      self_link.shift = shift_self;
   end

   assign link = self_link;

   always_comb begin
      valid_in = valid_ff;
      pixel_in = pixel_ff;
      seq_in   = seq_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_INSERT: begin
            if (shift_self || (!valid_ff && (first || prev_link.valid))) begin
               valid_in = 1'b1;
               if (!first && prev_link.shift) begin
                  pixel_in = prev_link.pixel;
                  seq_in   = prev_link.seq;
               end else begin
                  pixel_in = ctrl.new_pixel;
                  seq_in   = ctrl.new_seq;
               end
            end
         end
         OP_POP: begin
            if (last_cell) begin
               valid_in = 1'b0;
            end else begin
               valid_in = next_link.valid;
               pixel_in = next_link.pixel;
               seq_in   = next_link.seq;
            end
         end
         OP_SORT: begin
            if (odd_pos == ctrl.phase) begin
               if (!last_cell && precedes(next_link, self_link, ctrl.ascending)) begin
                  valid_in = next_link.valid;
                  pixel_in = next_link.pixel;
                  seq_in   = next_link.seq;
               end
            end else begin
               if (!first && precedes(self_link, prev_link, ctrl.ascending)) begin
                  valid_in = prev_link.valid;
                  pixel_in = prev_link.pixel;
                  seq_in   = prev_link.seq;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pixel_ff <= pixel_in;
      seq_ff   <= seq_in;
   end

endmodule

/* rtl/masked_run_pixel_sorter.sv */
// Top level of the masked run pixel sorter: sequencer, output register and cell chain.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_pixel, req_masked, req_end_of_line
//   rsp      out        rsp_valid/rsp_ready   rsp_pixel_out, rsp_line_done,
//                                             rsp_forced_split, rsp_last
//   csr      in         csr_valid/csr_ready   csr_ascending
//
// A masked request that neither meets a full chain nor ends the line is inserted without leaving idle.
// A flush pops the held pixels out of the chain head at one pixel a cycle while the output
// register is free, then emits a passed pixel or reinserts a masked one; a passed pixel
// with nothing held is emitted directly. The output register sets the pace.
// A mode write while pixels are held re-sorts the chain in alternating odd-even phases.
// Reset is synchronous and empties the chain; a stalled output holds the sequencer in flush and emit.
module masked_run_pixel_sorter #(
   parameter int MAX_RUN = mrps_pkg::MAX_RUN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mrps_pkg::PIXEL_W-1:0] req_pixel,
   input  logic                         req_masked,
   input  logic                         req_end_of_line,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mrps_pkg::PIXEL_W-1:0] rsp_pixel_out,
   output logic                         rsp_line_done,
   output logic                         rsp_forced_split,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_ascending
);
   import mrps_pkg::*;

   state_type          state_ff, state_in;
   logic               ascending_ff, ascending_in;
   logic [SEQ_W-1:0]   count_ff, count_in;
   logic [SEQ_W-1:0]   sweep_ff, sweep_in;
   logic [PIXEL_W-1:0] hold_pixel_ff, hold_pixel_in;
   logic               hold_masked_ff, hold_masked_in;
   logic               hold_eol_ff, hold_eol_in;
   logic               flush_forced_ff, flush_forced_in;
   logic               flush_final_ff, flush_final_in;
   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff, out_pixel_in;
   logic               out_line_done_ff, out_line_done_in;
   logic               out_forced_ff, out_forced_in;
   logic               out_last_ff, out_last_in;

   cell_ctrl_type      ctrl;
   link_type           links [MAX_RUN];
   logic [MAX_RUN-1:0] valid_vec;
   logic               out_free;
   logic               req_take;
   logic               chain_full;
   logic               chain_busy;
   logic               flush_end;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_RUN; gi++) begin : g_cell
         link_type prev_l;
         link_type next_l;
         if (gi == 0) begin : g_head
            assign prev_l = '0;
         end else begin : g_body
            assign prev_l = links[gi-1];
         end
         if (gi == MAX_RUN - 1) begin : g_tail
            assign next_l = '0;
         end else begin : g_inner
            assign next_l = links[gi+1];
         end
         mrps_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .prev_link (prev_l),
            .next_link (next_l),
            .first     (gi == 0),
            .last_cell (gi == MAX_RUN - 1),
            .odd_pos   ((gi % 2) == 1),
            .link      (links[gi])
         );
         assign valid_vec[gi] = links[gi].valid;
      end
   endgenerate

   assign chain_full = links[MAX_RUN-1].valid;
   assign chain_busy = links[0].valid;
   assign flush_end  = !links[1].valid;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_ready  = (state_ff == ST_IDLE) && !csr_valid;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               if (chain_busy) state_in = ST_RESORT;
            end else if (req_valid) begin
               if (req_masked) begin
                  if (chain_full || req_end_of_line) state_in = ST_FLUSH;
               end else begin
                  state_in = chain_busy ? ST_FLUSH : ST_EMIT;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free && flush_end) begin
               if (flush_final_ff)      state_in = ST_IDLE;
               else if (hold_masked_ff) state_in = ST_INSERT;
               else                     state_in = ST_EMIT;
            end
         end
         ST_INSERT: begin
            state_in = hold_eol_ff ? ST_FLUSH : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_RESORT: begin
            if (sweep_ff == SEQ_W'(MAX_RUN - 1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ascending_in     = ascending_ff;
      count_in         = count_ff;
      sweep_in         = sweep_ff;
      hold_pixel_in    = hold_pixel_ff;
      hold_masked_in   = hold_masked_ff;
      hold_eol_in      = hold_eol_ff;
      flush_forced_in  = flush_forced_ff;
      flush_final_in   = flush_final_ff;
      out_valid_in     = out_valid_ff && !rsp_ready;
      out_pixel_in     = out_pixel_ff;
      out_line_done_in = out_line_done_ff;
      out_forced_in    = out_forced_ff;
      out_last_in      = out_last_ff;
      ctrl.op          = OP_HOLD;
      ctrl.ascending   = ascending_ff;
      ctrl.phase       = sweep_ff[0];
      ctrl.new_pixel   = req_pixel;
      ctrl.new_seq     = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               ascending_in = csr_ascending;
               sweep_in     = '0;
            end else if (req_take) begin
               hold_pixel_in  = req_pixel;
               hold_masked_in = req_masked;
               hold_eol_in    = req_end_of_line;
               if (req_masked && chain_full) begin
                  flush_forced_in = 1'b1;
                  flush_final_in  = 1'b0;
               end else if (req_masked) begin
                  ctrl.op         = OP_INSERT;
                  count_in        = count_ff + SEQ_W'(1);
                  flush_forced_in = 1'b0;
                  flush_final_in  = 1'b1;
               end else begin
                  flush_forced_in = 1'b0;
                  flush_final_in  = 1'b0;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               ctrl.op          = OP_POP;
               out_valid_in     = 1'b1;
               out_pixel_in     = links[0].pixel;
               out_forced_in    = flush_forced_ff;
               out_last_in      = flush_end &&
                                  (flush_final_ff || (hold_masked_ff && !hold_eol_ff));
               out_line_done_in = flush_end && flush_final_ff && hold_eol_ff;
               if (flush_end) count_in = '0;
            end
         end
         ST_INSERT: begin
            ctrl.op         = OP_INSERT;
            ctrl.new_pixel  = hold_pixel_ff;
            count_in        = count_ff + SEQ_W'(1);
            flush_forced_in = 1'b0;
            flush_final_in  = 1'b1;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_pixel_in     = hold_pixel_ff;
               out_forced_in    = 1'b0;
               out_last_in      = 1'b1;
               out_line_done_in = hold_eol_ff;
            end
         end
         ST_RESORT: begin
            ctrl.op  = OP_SORT;
            sweep_in = sweep_ff + SEQ_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ascending_ff <= 1'b1;
         count_ff     <= '0;
         sweep_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ascending_ff <= ascending_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         out_valid_ff <= out_valid_in;
      end
      hold_pixel_ff    <= hold_pixel_in;
      hold_masked_ff   <= hold_masked_in;
      hold_eol_ff      <= hold_eol_in;
      flush_forced_ff  <= flush_forced_in;
      flush_final_ff   <= flush_final_in;
      out_pixel_ff     <= out_pixel_in;
      out_line_done_ff <= out_line_done_in;
      out_forced_ff    <= out_forced_in;
      out_last_ff      <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_out    = out_pixel_ff;
   assign rsp_line_done    = out_line_done_ff;
   assign rsp_forced_split = out_forced_ff;
   assign rsp_last         = out_last_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FLUSH |-> $countones(valid_vec) == 32'(count_ff))
      else $error("held pixel count disagrees with chain valid bits");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("chain valid bits are not a contiguous prefix");

   a_flush_has_data: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> links[0].valid)
      else $error("flush with an empty chain");

   a_insert_on_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> !links[0].valid)
      else $error("reinsertion into a chain that still holds pixels");

endmodule
